FILE: sv/gbc_pkg.sv
// Shared constants, types and the stick axis compare for the gamepad button conditioner.
package gbc_pkg;

    localparam int unsigned BTN_W   = 31;
    localparam int unsigned MASK_W  = 32;
    localparam int unsigned AXIS_W  = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned THR_W   = 15;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Direction bit positions in the hold mask
    localparam int unsigned BIT_REPEAT  = 31;
    localparam int unsigned BIT_L_LEFT  = 30;
    localparam int unsigned BIT_L_RIGHT = 29;
    localparam int unsigned BIT_L_UP    = 28;
    localparam int unsigned BIT_L_DOWN  = 27;
    localparam int unsigned BIT_R_LEFT  = 26;
    localparam int unsigned BIT_R_RIGHT = 25;
    localparam int unsigned BIT_R_UP    = 24;
    localparam int unsigned BIT_R_DOWN  = 23;

    localparam logic [MS_W-1:0]  RST_REPEAT_DELAY = '0;
    localparam logic [MS_W-1:0]  RST_REPEAT_PULSE = '0;
    localparam logic [THR_W-1:0] RST_PRESS_THR    = 15'd8192;  // 0.25 in Q0.15
    localparam logic [THR_W-1:0] RST_RELEASE_THR  = 15'd1638;  // 0.05 in Q0.15

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPEAT_DELAY = 2'd0,
        CFG_REPEAT_PULSE = 2'd1,
        CFG_PRESS_THR    = 2'd2,
        CFG_RELEASE_THR  = 2'd3
    } cfg_index_t;

    // Returns {neg_bit, pos_bit}; negative direction wins.
    function automatic logic [1:0] axis_dir(
        input logic signed [AXIS_W-1:0] axis,
        input logic [THR_W-1:0]         press_thr,
        input logic [THR_W-1:0]         release_thr,
        input logic                     neg_prev,
        input logic                     pos_prev
    );
        logic signed [AXIS_W:0] a_x;
        logic signed [AXIS_W:0] p_pos;
        logic signed [AXIS_W:0] r_pos;
        logic                   neg_hit;
        logic                   pos_hit;
        a_x     = {axis[AXIS_W-1], axis};
        p_pos   = {2'b00, press_thr};
        r_pos   = {2'b00, release_thr};
        neg_hit = (a_x <= -p_pos) || (neg_prev && (a_x <= -r_pos));
        pos_hit = !neg_hit && ((a_x >= p_pos) || (pos_prev && (a_x >= r_pos)));
        return {neg_hit, pos_hit};
    endfunction

endpackage

FILE: sv/gamepad_button_conditioner.sv
// Gamepad button conditioner: stick-to-direction hysteresis, edge detect and repeat pulse.
//
// One poll sample per request in, one result per request out, one request per cycle
// sustained while m_ready stays high. A sample is captured into an input register;
// once the result register is free, the direction compares, the edge masks and the
// repeat timer test run in a single combinational pass and land in the result
// register, together with the update of the previous hold mask and the two
// timestamps. m_valid is driven by the result register, so a sample passes the input
// register and then the result register before m_valid shows it. The state update
// happens when a sample moves into the result register, so the following sample
// (already in the input register) sees it in the next cycle; that state loop sets
// the rate. Input and result registers decouple the channels: a new sample is taken
// while a finished result still waits for m_ready. Configuration (cfg_wr_en /
// cfg_index / cfg_wdata) is registered on cfg_wr_en and must only change while no
// sample is in flight. Bit 31 of hold_mask is the repeat pulse; it never enters the
// edge masks or the change test.
module gamepad_button_conditioner
    import gbc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata,
    // sample request
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [BTN_W-1:0]         s_button_bits,
    input  logic signed [AXIS_W-1:0] s_left_x,
    input  logic signed [AXIS_W-1:0] s_left_y,
    input  logic signed [AXIS_W-1:0] s_right_x,
    input  logic signed [AXIS_W-1:0] s_right_y,
    input  logic [TIME_W-1:0]        s_time_ms,
    // result request
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [MASK_W-1:0]        m_hold_mask,
    output logic [BTN_W-1:0]         m_pressed_edges,
    output logic [BTN_W-1:0]         m_released_edges
);

    // ---------------- configuration registers ----------------
    logic [MS_W-1:0]  repeat_delay_reg;
    logic [MS_W-1:0]  repeat_pulse_reg;
    logic [THR_W-1:0] press_thr_reg;
    logic [THR_W-1:0] release_thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repeat_delay_reg <= RST_REPEAT_DELAY;
            repeat_pulse_reg <= RST_REPEAT_PULSE;
            press_thr_reg    <= RST_PRESS_THR;
            release_thr_reg  <= RST_RELEASE_THR;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_REPEAT_DELAY: repeat_delay_reg <= cfg_wdata;
                CFG_REPEAT_PULSE: repeat_pulse_reg <= cfg_wdata;
                CFG_PRESS_THR:    press_thr_reg    <= cfg_wdata[THR_W-1:0];
                CFG_RELEASE_THR:  release_thr_reg  <= cfg_wdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                     in_valid_reg;
    logic [BTN_W-1:0]         in_buttons_reg;
    logic signed [AXIS_W-1:0] in_lx_reg;
    logic signed [AXIS_W-1:0] in_ly_reg;
    logic signed [AXIS_W-1:0] in_rx_reg;
    logic signed [AXIS_W-1:0] in_ry_reg;
    logic [TIME_W-1:0]        in_time_reg;

    logic out_valid_reg;
    logic out_free;
    logic fire;    // sample moves from input register to result register

    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_buttons_reg <= s_button_bits;
            in_lx_reg      <= s_left_x;
            in_ly_reg      <= s_left_y;
            in_rx_reg      <= s_right_x;
            in_ry_reg      <= s_right_y;
            in_time_reg    <= s_time_ms;
        end
    end

    // ---------------- conditioning state ----------------
    logic [BTN_W-1:0]  prev_hold_reg;
    logic [TIME_W-1:0] change_time_reg;
    logic [TIME_W-1:0] pulse_time_reg;

    // ---------------- single combinational pass ----------------
    logic [1:0]        lx_dir;
    logic [1:0]        ly_dir;
    logic [1:0]        rx_dir;
    logic [1:0]        ry_dir;
    logic [BTN_W-1:0]  dir_bits;
    logic [BTN_W-1:0]  hold_now;
    logic              mask_changed;
    logic [TIME_W-1:0] change_time_next;
    logic [TIME_W-1:0] pulse_base;
    logic [TIME_W-1:0] pulse_time_next;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_pulse;
    logic              repeat_hit;

    // Hysteresis looks at the previous hold, which already includes any
    // direction bits that came in through button_bits.
    assign lx_dir = axis_dir(in_lx_reg, press_thr_reg, release_thr_reg,
                             prev_hold_reg[BIT_L_LEFT], prev_hold_reg[BIT_L_RIGHT]);
    assign ly_dir = axis_dir(in_ly_reg, press_thr_reg, release_thr_reg,
                             prev_hold_reg[BIT_L_DOWN], prev_hold_reg[BIT_L_UP]);
    assign rx_dir = axis_dir(in_rx_reg, press_thr_reg, release_thr_reg,
                             prev_hold_reg[BIT_R_LEFT], prev_hold_reg[BIT_R_RIGHT]);
    assign ry_dir = axis_dir(in_ry_reg, press_thr_reg, release_thr_reg,
                             prev_hold_reg[BIT_R_DOWN], prev_hold_reg[BIT_R_UP]);

    always_comb begin
        dir_bits              = '0;
        dir_bits[BIT_L_LEFT]  = lx_dir[1];
        dir_bits[BIT_L_RIGHT] = lx_dir[0];
        dir_bits[BIT_L_DOWN]  = ly_dir[1];
        dir_bits[BIT_L_UP]    = ly_dir[0];
        dir_bits[BIT_R_LEFT]  = rx_dir[1];
        dir_bits[BIT_R_RIGHT] = rx_dir[0];
        dir_bits[BIT_R_DOWN]  = ry_dir[1];
        dir_bits[BIT_R_UP]    = ry_dir[0];
    end

    assign hold_now     = in_buttons_reg | dir_bits;
    assign mask_changed = (hold_now != prev_hold_reg);

    // A mask change restarts both timers at the sample time.
    assign change_time_next = mask_changed ? in_time_reg : change_time_reg;
    assign pulse_base       = mask_changed ? in_time_reg : pulse_time_reg;

    // Wrapping differences
    assign since_change = in_time_reg - change_time_next;
    assign since_pulse  = in_time_reg - pulse_base;

    assign repeat_hit = (repeat_pulse_reg != '0)
                     && (since_change >= {{(TIME_W-MS_W){1'b0}}, repeat_delay_reg})
                     && (since_pulse  >  {{(TIME_W-MS_W){1'b0}}, repeat_pulse_reg});

    assign pulse_time_next = repeat_hit ? in_time_reg : pulse_base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_hold_reg   <= '0;
            change_time_reg <= '0;
            pulse_time_reg  <= '0;
        end else if (fire) begin
            prev_hold_reg   <= hold_now;
            change_time_reg <= change_time_next;
            pulse_time_reg  <= pulse_time_next;
        end
    end

    // ---------------- result register ----------------
    logic [MASK_W-1:0] hold_mask_reg;
    logic [BTN_W-1:0]  pressed_reg;
    logic [BTN_W-1:0]  released_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            hold_mask_reg <= {repeat_hit, hold_now};
            pressed_reg   <= hold_now & ~prev_hold_reg;
            released_reg  <= prev_hold_reg & ~hold_now;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_hold_mask      = hold_mask_reg;
    assign m_pressed_edges  = pressed_reg;
    assign m_released_edges = released_reg;

    // ---------------- assertions ----------------
    // A bit cannot both rise and fall in one sample.
    a_edges_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((pressed_reg & released_reg) == '0))
        else $error("pressed and released edges overlap");

    // A newly pressed bit must be held in the same result.
    a_pressed_held: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((pressed_reg & ~hold_mask_reg[BTN_W-1:0]) == '0))
        else $error("pressed edge without hold bit");

    // A mask change restarts the pulse timer, so no repeat on an edge sample.
    a_no_repeat_on_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && ((pressed_reg | released_reg) != '0) |-> !hold_mask_reg[BIT_REPEAT])
        else $error("repeat pulse together with a mask change");

    // State advances only when a sample is consumed.
    a_state_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(prev_hold_reg) && $stable(pulse_time_reg))
        else $error("conditioning state changed without a sample");

    // A sample waiting in the input register is not dropped.
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !fire |=> in_valid_reg)
        else $error("buffered sample lost");

endmodule
